// ===== rtl/kts_pkg.sv =====
// Shared types and codes for the keyframe track sampler.
package kts_pkg;

   localparam int TICK_W  = 32;
   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 9;
   localparam int LIMIT_W = 9;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = VALUE_W + 1 + FRAC_W;

   localparam logic [LIMIT_W-1:0] KEY_LIMIT_RESET = 9'd256;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_EVAL   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_LIMIT = 2'd2;
   localparam logic [1:0] STAT_ORDER = 2'd3;

   typedef struct packed {
      logic [1:0]                func;
      logic [TICK_W-1:0]         tick;
      logic signed [VALUE_W-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sampled_value;
      logic [1:0]                status;
      logic [TOTAL_W-1:0]        key_total;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]         tick;
      logic signed [VALUE_W-1:0] value;
   } key_type;

endpackage

// ===== rtl/kts_key_store.sv =====
// Key memory: one write port, one registered read port.
module kts_key_store
   import kts_pkg::*;
#(
   parameter int MAX_KEYS = 256,
   parameter int AW       = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  key_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output key_type       rd_data
);

   key_type mem [MAX_KEYS];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kts_frac_div.sv =====
// Restoring divider, one quotient bit per cycle: floor((off << 16) / span), off < span.
module kts_frac_div
   import kts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TICK_W-1:0] off,
   input  logic [TICK_W-1:0] span,
   output logic              done,
   output logic [FRAC_W-1:0] quotient
);

   localparam int CNT_W = $clog2(FRAC_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [TICK_W-1:0] span_ff, span_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [TICK_W:0]   rem_dbl;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      quo_in  = quo_ff;
      rem_dbl = {rem_ff, 1'b0};
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = off;
         span_in = span;
         quo_in  = '0;
      end else if (run_ff) begin
         // remainder stays below span, so the doubled value fits one extra bit
         if (rem_dbl >= {1'b0, span_ff}) begin
            rem_in = TICK_W'(rem_dbl - {1'b0, span_ff});
            quo_in = {quo_ff[FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl[TICK_W-1:0];
            quo_in = {quo_ff[FRAC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/kts_step_mul.sv =====
// Shift-add multiplier, one fraction bit per cycle, MSB first: diff * frac.
module kts_step_mul
   import kts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [VALUE_W:0]  diff,
   input  logic [FRAC_W-1:0]        frac,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   localparam int CNT_W = $clog2(FRAC_W);

   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [VALUE_W:0]  diff_ff, diff_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      diff_in = diff_ff;
      frac_in = frac_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         diff_in = diff;
         frac_in = frac;
         acc_in  = '0;
      end else if (run_ff) begin
         if (frac_ff[FRAC_W-1]) begin
            acc_in = (acc_ff <<< 1) + PROD_W'(diff_ff);
         end else begin
            acc_in = acc_ff <<< 1;
         end
         frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      diff_ff <= diff_in;
      frac_ff <= frac_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/keyframe_track_sampler.sv =====
// Keyframe track sampler: one key track with clamped linear interpolation.
//
// Items enter on req_* (valid/ready) and each gives exactly one item on rsp_*.
// func clear empties the track, append adds a key at the end (refused with a
// status when full or when its tick does not rise), evaluate samples the
// track at a tick. csr_we/csr_wdata set the key limit at any idle time.
// One item is worked at a time; req_ready is high only when the sequencer is
// idle, so the next item can be accepted in the same cycle that the last result enters the output register.
// Clear, append and unused codes go from accept through S_FIN to rsp_valid.
// An evaluate that clamps or hits the first/last key takes the same path;
// an interior evaluate runs a binary search over the key memory, one memory
// read per probe (S_PROBE, S_CMP), then reads the key pair (S_HI, S_LO; an
// exact hit on the upper key goes straight to S_FIN), then runs a 16-bit
// bit-serial divide and a 16-bit bit-serial multiply before S_FIN.
// The result sits in an output register; a stalled receiver holds it there
// and the next item's result waits in the sequencer until the slot frees.
// Reset (synchronous) empties the track, sets the key limit to 256 and drops
// rsp_valid. Key memory contents are not cleared; only written keys are read.
module keyframe_track_sampler
   import kts_pkg::*;
#(
   parameter int MAX_KEYS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PROBE = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_HI    = 4'd3;
   localparam logic [3:0] S_LO    = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;

   logic [3:0]                state_ff, state_in;
   logic [LIMIT_W-1:0]        key_limit_ff, key_limit_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [TICK_W-1:0]         first_tick_ff, first_tick_in;
   logic signed [VALUE_W-1:0] first_val_ff, first_val_in;
   logic [TICK_W-1:0]         last_tick_ff, last_tick_in;
   logic signed [VALUE_W-1:0] last_val_ff, last_val_in;
   logic [TICK_W-1:0]         qtick_ff, qtick_in;
   logic [AW-1:0]             lo_ff, lo_in;
   logic [AW-1:0]             hi_ff, hi_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic [TICK_W-1:0]         t_hi_ff, t_hi_in;
   logic signed [VALUE_W-1:0] v_hi_ff, v_hi_in;
   logic signed [VALUE_W-1:0] v_lo_ff, v_lo_in;
   logic signed [VALUE_W-1:0] res_val_ff, res_val_in;
   logic [1:0]                res_stat_ff, res_stat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic [LW-1:0]             lim;
   logic                      wr_en;
   key_type                   wr_data;
   logic [AW-1:0]             rd_addr;
   key_type                   rd_data;
   logic                      div_start, div_done;
   logic [TICK_W-1:0]         div_off, div_span;
   logic [FRAC_W-1:0]         div_quo;
   logic                      mul_start, mul_done;
   logic signed [VALUE_W:0]   mul_diff;
   logic signed [PROD_W-1:0]  mul_prod;

   assign accept = req_valid && req_ready;
   assign lim    = (LW'(key_limit_ff) < LW'(MAX_KEYS)) ? LW'(key_limit_ff) : LW'(MAX_KEYS);

   assign wr_data = {req_payload.tick, req_payload.key_value};

   assign div_off  = qtick_ff - rd_data.tick;
   assign div_span = t_hi_ff - rd_data.tick;
   assign mul_diff = {v_hi_ff[VALUE_W-1], v_hi_ff} - {v_lo_ff[VALUE_W-1], v_lo_ff};

   always_comb begin
      state_in      = state_ff;
      key_limit_in  = csr_we ? csr_wdata : key_limit_ff;
      count_in      = count_ff;
      first_tick_in = first_tick_ff;
      first_val_in  = first_val_ff;
      last_tick_in  = last_tick_ff;
      last_val_in   = last_val_ff;
      qtick_in      = qtick_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      t_hi_in       = t_hi_ff;
      v_hi_in       = v_hi_ff;
      v_lo_in       = v_lo_ff;
      res_val_in    = res_val_ff;
      res_stat_in   = res_stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      rd_addr       = lo_ff;
      div_start     = 1'b0;
      mul_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_val_in  = '0;
               res_stat_in = STAT_OK;
               state_in    = S_FIN;
               case (req_payload.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (LW'(count_ff) >= lim) begin
                        res_stat_in = STAT_LIMIT;
                     end else if ((count_ff != '0) && (req_payload.tick <= last_tick_ff)) begin
                        res_stat_in = STAT_ORDER;
                     end else begin
                        wr_en        = 1'b1;
                        count_in     = count_ff + 1'b1;
                        last_tick_in = req_payload.tick;
                        last_val_in  = req_payload.key_value;
                        if (count_ff == '0) begin
                           first_tick_in = req_payload.tick;
                           first_val_in  = req_payload.key_value;
                        end
                     end
                  end
                  FUNC_EVAL: begin
                     if (count_ff == '0) begin
                        res_stat_in = STAT_EMPTY;
                     end else if (req_payload.tick <= first_tick_ff) begin
                        res_val_in = first_val_ff;
                     end else if (req_payload.tick >= last_tick_ff) begin
                        res_val_in = last_val_ff;
                     end else begin
                        // strictly inside: at least two keys, search [1, n-1]
                        qtick_in = req_payload.tick;
                        lo_in    = AW'(1);
                        hi_in    = AW'(count_ff - 1'b1);
                        state_in = S_PROBE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               rd_addr  = mid_in;
               state_in = S_CMP;
            end else begin
               rd_addr  = lo_ff;
               state_in = S_HI;
            end
         end
         S_CMP: begin
            if (rd_data.tick < qtick_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_PROBE;
         end
         S_HI: begin
            t_hi_in = rd_data.tick;
            v_hi_in = rd_data.value;
            if (rd_data.tick == qtick_ff) begin
               res_val_in = rd_data.value;
               state_in   = S_FIN;
            end else begin
               rd_addr  = lo_ff - 1'b1;
               state_in = S_LO;
            end
         end
         S_LO: begin
            v_lo_in   = rd_data.value;
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               // arithmetic shift by 16 floors toward minus infinity
               res_val_in = v_lo_ff + mul_prod[VALUE_W+FRAC_W-1:FRAC_W];
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.sampled_value  = res_val_ff;
               rsp_in.status         = res_stat_ff;
               rsp_in.key_total      = TOTAL_W'(count_ff);
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_limit_ff <= KEY_LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_limit_ff <= key_limit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_tick_ff <= first_tick_in;
      first_val_ff  <= first_val_in;
      last_tick_ff  <= last_tick_in;
      last_val_ff   <= last_val_in;
      qtick_ff      <= qtick_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      t_hi_ff       <= t_hi_in;
      v_hi_ff       <= v_hi_in;
      v_lo_ff       <= v_lo_in;
      res_val_ff    <= res_val_in;
      res_stat_ff   <= res_stat_in;
      rsp_ff        <= rsp_in;
   end

   kts_key_store #(
      .MAX_KEYS (MAX_KEYS),
      .AW       (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kts_frac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .off      (div_off),
      .span     (div_span),
      .done     (div_done),
      .quotient (div_quo)
   );

   kts_step_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .diff    (mul_diff),
      .frac    (div_quo),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== verif/kts_checker.sv =====
// Checker for the keyframe track sampler: predicts each result and compares it.
`timescale 1ns / 1ps

module kts_checker
   import kts_pkg::*;
#(
   parameter int MAX_KEYS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 results_checked
);

   // Shadow copy of the track and the key limit
   logic [TICK_W-1:0]         trk_tick  [MAX_KEYS];
   logic signed [VALUE_W-1:0] trk_value [MAX_KEYS];
   int unsigned               key_count;
   logic [LIMIT_W-1:0]        key_limit;

   rsp_type expected_q [$];

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t: mismatch on %s: got 0x%h, expected 0x%h", $time, field, got, want);
      end
   endtask

   function automatic logic [VALUE_W-1:0] sample_track(logic [TICK_W-1:0] at);
      int unsigned       n;
      int unsigned       idx;
      logic [TICK_W-1:0] span;
      logic [TICK_W-1:0] off;
      logic [47:0]       scaled;
      logic [FRAC_W-1:0] frac;
      longint            diff;
      longint            prod;
      longint            sum;
      n = key_count;
      if (at <= trk_tick[0]) return trk_value[0];
      if (at >= trk_tick[n-1]) return trk_value[n-1];
      // first key at or above the query tick; ticks rise strictly
      idx = 1;
      while (trk_tick[idx] < at) idx++;
      if (trk_tick[idx] == at) return trk_value[idx];
      span   = trk_tick[idx] - trk_tick[idx-1];
      off    = at - trk_tick[idx-1];
      scaled = {off, 16'h0000} / {16'h0000, span};
      frac   = scaled[FRAC_W-1:0];
      diff   = longint'(trk_value[idx]) - longint'(trk_value[idx-1]);
      prod   = diff * longint'(frac);
      // arithmetic shift gives the floor for negative products
      sum    = longint'(trk_value[idx-1]) + (prod >>> FRAC_W);
      return sum[VALUE_W-1:0];
   endfunction

   function automatic rsp_type track_step(req_type item);
      rsp_type     r;
      int unsigned cap;
      r   = '0;
      cap = (key_limit < MAX_KEYS) ? key_limit : MAX_KEYS;
      case (item.func)
         FUNC_CLEAR: key_count = 0;
         FUNC_APPEND: begin
            if (key_count >= cap) begin
               r.status = STAT_LIMIT;
            end else if (key_count > 0 && item.tick <= trk_tick[key_count-1]) begin
               r.status = STAT_ORDER;
            end else begin
               trk_tick[key_count]  = item.tick;
               trk_value[key_count] = item.key_value;
               key_count++;
            end
         end
         FUNC_EVAL: begin
            if (key_count == 0) r.status = STAT_EMPTY;
            else r.sampled_value = sample_track(item.tick);
         end
         default: ;
      endcase
      r.key_total = TOTAL_W'(key_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         expected_q.delete();
         key_count = 0;
         key_limit = KEY_LIMIT_RESET;
      end else begin
         if (csr_we) key_limit = csr_wdata;
         if (req_valid && req_ready) expected_q.push_back(track_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no item waiting", rsp_payload.sampled_value, 0);
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (rsp_payload.sampled_value !== want.sampled_value)
                  report_mismatch("sampled_value", rsp_payload.sampled_value,
                                  want.sampled_value);
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.key_total !== want.key_total)
                  report_mismatch("key_total", rsp_payload.key_total, want.key_total);
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the keyframe track sampler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
   import kts_pkg::*;

   localparam int         MAX_KEYS    = 256;
   localparam int         CYCLE_LIMIT = 500000;
   localparam int         HOLD_CYCLES = 150;
   localparam int         RANDOM_ITEMS = 650;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_payload;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_payload;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int results_checked;
   int cycle_count;
   int items_sent;
   int limits_written;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   logic [LIMIT_W-1:0] limit_plan [12] = '{9'd256, 9'd1, 9'd2, 9'd300, 9'd5, 9'd0,
                                           9'd511, 9'd17, 9'd256, 9'd64, 9'd3, 9'd128};

   keyframe_track_sampler #(.MAX_KEYS(MAX_KEYS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   kts_checker #(.MAX_KEYS(MAX_KEYS)) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: short random stalls, plus one long hold-off on request
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic [1:0] func, logic [31:0] tick, logic [31:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{func: func, tick: tick, key_value: value};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Let every outstanding result drain so the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] lim);
      csr_we    <= 1'b1;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we    <= 1'b0;
      limits_written++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_tick(logic [31:0] marks[$]);
      int          i;
      logic [31:0] lo;
      logic [31:0] hi;
      if (marks.size() == 0) return $urandom;
      i  = $urandom_range(0, marks.size() - 1);
      lo = marks[0];
      hi = marks[marks.size()-1];
      case ($urandom_range(0, 6))
         0: return marks[i];
         1: return marks[i] + 1;
         2: return marks[i] - 1;
         3: return (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
         4: return $urandom_range(0, lo);
         5: return $urandom_range(hi, 32'hFFFF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // Broken or stray item dropped into the middle of a track build
   task automatic noise_item(logic [31:0] last_tick);
      case ($urandom_range(0, 3))
         0: send_item(FUNC_APPEND, last_tick, $urandom);
         1: send_item(FUNC_APPEND, $urandom_range(0, last_tick), $urandom);
         2: send_item(FUNC_UNUSED, $urandom, $urandom);
         default: send_item(FUNC_EVAL, $urandom, $urandom);
      endcase
   endtask

   // Build a fresh track with rising ticks, then sample it
   task automatic probe_track(int n_keys, int n_evals);
      logic [31:0] marks[$];
      logic [31:0] at;
      logic [31:0] gap_max;
      send_item(FUNC_CLEAR, $urandom, $urandom);
      at      = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      gap_max = (n_keys > 16) ? 32'h0040_0000 : 32'h0100_0000;
      for (int k = 0; k < n_keys; k++) begin
         send_item(FUNC_APPEND, at, pick_value());
         marks.push_back(at);
         if ($urandom_range(0, 9) == 0) noise_item(at);
         case ($urandom_range(0, 3))
            0: at += 1;
            1: at += $urandom_range(1, 255);
            default: at += $urandom_range(1, gap_max);
         endcase
      end
      for (int k = 0; k < n_evals; k++) begin
         send_item(FUNC_EVAL, pick_tick(marks), $urandom);
      end
   endtask

   initial begin : stimulus
      int               stop_at;
      int               phase;
      int               n_keys;
      bit               big_done;
      logic [LIMIT_W-1:0] lim;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      big_done    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty track, ordering refusals, clamps, hits and extremes
      send_item(FUNC_EVAL,   32'h1234_5678, 32'h0);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(FUNC_APPEND, 32'h0001_0000, 32'h8000_0000);
      send_item(FUNC_APPEND, 32'h0001_0000, 32'h0);
      send_item(FUNC_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
      send_item(FUNC_APPEND, 32'h0003_0000, 32'h7FFF_FFFF);
      send_item(FUNC_APPEND, 32'h0003_0001, 32'h8000_0000);
      send_item(FUNC_APPEND, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(FUNC_EVAL,   32'h0000_0000, 32'h0);
      send_item(FUNC_EVAL,   32'h0001_0000, 32'h0);
      send_item(FUNC_EVAL,   32'h0002_0000, 32'h0);
      send_item(FUNC_EVAL,   32'h0001_0001, 32'h0);
      send_item(FUNC_EVAL,   32'h0002_FFFF, 32'h0);
      send_item(FUNC_EVAL,   32'h0003_0000, 32'h0);
      send_item(FUNC_EVAL,   32'h8000_0000, 32'hFFFF_FFFF);
      send_item(FUNC_EVAL,   32'hFFFF_FFFE, 32'h0);
      send_item(FUNC_EVAL,   32'hFFFF_FFFF, 32'h0);
      send_item(FUNC_APPEND, 32'hFFFF_FFFF, 32'h0);
      send_item(FUNC_CLEAR,  32'hFFFF_FFFF, 32'h8000_0000);
      send_item(FUNC_EVAL,   32'h0000_0000, 32'h0);
      send_item(FUNC_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(FUNC_EVAL,   32'h0000_0000, 32'h0);
      send_item(FUNC_APPEND, 32'h0000_0000, 32'h0);
      send_item(FUNC_CLEAR,  32'h0, 32'h0);
      send_item(FUNC_APPEND, 32'h0000_0000, 32'h0);

      // Limit of one: the limit check wins over a non-rising tick
      drain();
      write_limit(9'd1);
      send_item(FUNC_APPEND, 32'h0000_0000, 32'h5);
      send_item(FUNC_CLEAR,  32'h0, 32'h0);
      send_item(FUNC_APPEND, 32'h0000_0010, 32'h5);
      send_item(FUNC_EVAL,   32'h0000_0011, 32'h0);
      // Zero limit refuses every append, even on an empty track
      drain();
      write_limit(9'd0);
      send_item(FUNC_APPEND, 32'h0000_0020, 32'h5);
      send_item(FUNC_CLEAR,  32'h0, 32'h0);
      send_item(FUNC_APPEND, 32'h0000_0020, 32'h5);
      send_item(FUNC_EVAL,   32'h0000_0020, 32'h0);

      stop_at = items_sent + RANDOM_ITEMS;
      phase   = 0;
      while (items_sent < stop_at) begin
         lim = limit_plan[phase % 12];
         drain();
         if (items_sent > stop_at - 100) idle_on = 1'b0;
         write_limit(lim);
         // hold the result side long enough to back the block up
         if (phase == 0) hold_request = 1'b1;
         repeat (3) begin
            n_keys = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            if (lim == 9'd300 && !big_done) begin
               big_done = 1'b1;
               probe_track(260, 30);
            end else begin
               probe_track(n_keys, $urandom_range(2, 10));
            end
         end
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Run sent %0d items across %0d key-limit writes; %0d results compared.",
               items_sent, limits_written, results_checked);
      $display("Tracks from one key up to a full table, with clamps, hits and interpolation.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/kts_pkg.sv
rtl/kts_key_store.sv
rtl/kts_frac_div.sv
rtl/kts_step_mul.sv
rtl/keyframe_track_sampler.sv
verif/kts_checker.sv
verif/tb.sv
